>>> rtl/core/lsa_rl_pkg.sv
// shared types for the link-state retransmission list: entry layout, request kinds,
// and the per-cycle control word that the core sends to every list cell
// no dependencies
package lsa_rl_pkg;

    // one list entry, packed so the key sits in the low bits as on the stream bus
    typedef struct packed {
        logic [15:0] check_value;
        logic [31:0] sequence_req;
        logic [31:0] origin_router;
        logic [31:0] state_id;
        logic [15:0] lsa_type;
    } entry_t;

    localparam int unsigned EntryWidth = $bits(entry_t);

    typedef enum logic [1:0] {
        KIND_QUEUE = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // control broadcast to all cells
    typedef struct packed {
        logic capture;   // register key and full compare flags
        logic update;    // overwrite the entry whose key hit
        logic append;    // write the first free cell
        logic ack;       // drop the fully matching entry and close the gap
        logic clear;     // empty the list
    } cell_ctrl_t;

endpackage

>>> rtl/core/lsa_rl_cell.sv
// one cell of the retransmission list: holds one entry and its occupied flag,
// compares against the broadcast request and shifts from its right neighbor
// depends on lsa_rl_pkg
module lsa_rl_cell import lsa_rl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  entry_t     req_entry,
    input  cell_ctrl_t ctrl,
    input  logic       left_occ,
    input  logic       left_shift,
    input  entry_t     right_entry,
    input  logic       right_occ,
    output logic       occ,
    output entry_t     entry,
    output logic       key_hit,
    output logic       full_hit,
    output logic       shift_out
);

    logic   occ_reg, occ_next;
    entry_t entry_reg, entry_next;
    logic   key_hit_reg, key_hit_next;
    logic   full_hit_reg, full_hit_next;
    logic   key_eq, full_eq;

    assign key_eq  = (entry_reg.lsa_type == req_entry.lsa_type) &&
                     (entry_reg.state_id == req_entry.state_id) &&
                     (entry_reg.origin_router == req_entry.origin_router);
    assign full_eq = key_eq && (entry_reg.sequence_req == req_entry.sequence_req) &&
                     (entry_reg.check_value == req_entry.check_value);

    // this cell or one to its left is removed: take the right neighbor
    assign shift_out = left_shift | full_hit_reg;

    always_comb begin
        occ_next      = occ_reg;
        entry_next    = entry_reg;
        key_hit_next  = key_hit_reg;
        full_hit_next = full_hit_reg;
        if (ctrl.capture) begin
            key_hit_next  = occ_reg & key_eq;
            full_hit_next = occ_reg & full_eq;
        end
        if (ctrl.update && key_hit_reg) begin
            entry_next = req_entry;
        end
        if (ctrl.append && !occ_reg && left_occ) begin
            entry_next = req_entry;
            occ_next   = 1'b1;
        end
        if (ctrl.ack && shift_out) begin
            entry_next = right_entry;
            occ_next   = right_occ;
        end
        if (ctrl.clear) begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= 1'b0;
            key_hit_reg  <= 1'b0;
            full_hit_reg <= 1'b0;
        end else begin
            occ_reg      <= occ_next;
            key_hit_reg  <= key_hit_next;
            full_hit_reg <= full_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign occ      = occ_reg;
    assign entry    = entry_reg;
    assign key_hit  = key_hit_reg;
    assign full_hit = full_hit_reg;

endmodule

>>> rtl/core/lsa_retransmission_list_core.sv
// top level of the link-state retransmission list: request sequencer, cell row,
// capacity register and result register
// depends on lsa_rl_pkg and lsa_rl_cell
//
// The list is a row of DEPTH cells, each holding one entry (key = type, id,
// router, plus sequence and checksum) and an occupied flag; occupied cells
// always form a prefix of the row, so the list order is the cell order. A
// request (kind in s_tuser) is registered on acceptance, every cell compares it
// in the next cycle and registers its hit flags; then, once the output
// register is free, the row is updated and the response is written to it.
// A request passes through this capture / compare / update sequence
// through the cell row before the next request is taken in the cycle
// after the update, while the previous response may still wait in the
// output register. A queue request overwrites the entry with the same key or
// appends at the end of the list while the count is below
// min(capacity_limit, DEPTH); an acknowledge removes the entry that matches on
// all five fields and every later entry moves one cell to the left, keeping
// order. Keys are unique in the list, so at most one entry ever matches.
// capacity_limit (cfg_data) resets to 32 and is written whenever cfg_valid is
// high; write it only while no request is in flight. No clearing pass is
// needed after reset: only the occupied and hit flags are reset.
module lsa_retransmission_list_core import lsa_rl_pkg::*; #(
    parameter int unsigned DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // lsa_type[15:0], state_id, origin_router,
                                    // sequence_req, check_value[127:112]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    // response channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // ok[0], entry_count[6:1], zero pad[7]
    // capacity limit write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = (CW > 6) ? CW : 6;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    kind_t           kind_reg, kind_next;
    entry_t          req_reg, req_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [5:0]      limit_reg;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      m_tdata_reg, m_tdata_next;

    cell_ctrl_t      ctrl;
    logic            out_free;
    logic            any_key, any_full, room;
    logic [LW-1:0]   count_ext, limit_ext, depth_ext, eff_limit, count_out_ext;
    logic            ok;

    // cell row wiring, one slot per cell
    logic            occ_vec   [DEPTH];
    entry_t          entry_vec [DEPTH];
    logic            shift_vec [DEPTH];
    logic [DEPTH-1:0] key_hit_vec, full_hit_vec, occ_bits;

    // configuration: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 6'd32;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic   l_occ, l_shift, r_occ;
            entry_t r_entry;
            if (gi == 0) begin : g_first
                assign l_occ   = 1'b1;
                assign l_shift = 1'b0;
            end else begin : g_mid
                assign l_occ   = occ_vec[gi-1];
                assign l_shift = shift_vec[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign r_occ   = 1'b0;
                assign r_entry = '0;
            end else begin : g_inner
                assign r_occ   = occ_vec[gi+1];
                assign r_entry = entry_vec[gi+1];
            end
            lsa_rl_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .req_entry   (req_reg),
                .ctrl        (ctrl),
                .left_occ    (l_occ),
                .left_shift  (l_shift),
                .right_entry (r_entry),
                .right_occ   (r_occ),
                .occ         (occ_vec[gi]),
                .entry       (entry_vec[gi]),
                .key_hit     (key_hit_vec[gi]),
                .full_hit    (full_hit_vec[gi]),
                .shift_out   (shift_vec[gi])
            );
            assign occ_bits[gi] = occ_vec[gi];
        end
    endgenerate

    // hit summary and room check
    assign any_key   = |key_hit_vec;
    assign any_full  = |full_hit_vec;
    assign count_ext = LW'(count_reg);
    assign limit_ext = LW'(limit_reg);
    assign depth_ext = LW'(DEPTH);
    assign eff_limit = (limit_ext < depth_ext) ? limit_ext : depth_ext;
    assign room      = count_ext < eff_limit;

    // output register can take a response this cycle
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ctrl          = '0;
        ok            = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = kind_t'(s_tuser);
                    req_next   = entry_t'(s_tdata);
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                ctrl.capture = 1'b1;
                state_next   = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    unique case (kind_reg)
                        KIND_QUEUE: begin
                            if (any_key) begin
                                ctrl.update = 1'b1;
                                ok          = 1'b1;
                            end else if (room) begin
                                ctrl.append = 1'b1;
                                count_next  = count_reg + CW'(1);
                                ok          = 1'b1;
                            end
                        end
                        KIND_ACK: begin
                            if (any_full) begin
                                ctrl.ack   = 1'b1;
                                count_next = count_reg - CW'(1);
                                ok         = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            ok = any_key;
                        end
                        KIND_CLEAR: begin
                            ctrl.clear = 1'b1;
                            count_next = '0;
                            ok         = 1'b1;
                        end
                        default: begin
                            ok = 1'b0;
                        end
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, count_out_ext[5:0], ok};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_out_ext = LW'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // request and response payload
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        req_reg     <= req_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // count tracks the occupied cells
    a_count_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_bits) == count_reg)
        else $error("entry count disagrees with occupied cells");

    // keys are unique, so at most one cell hits
    a_key_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(key_hit_vec))
        else $error("more than one cell holds the same key");

    // count never exceeds the row
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // a response only comes out of the update cycle
    a_resp_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("response raised outside the update cycle");

endmodule

>>> bench/lsa_list_checker.sv
`timescale 1ns / 100ps
// response checker for the link-state retransmission list: keeps its own copy of the list
// and capacity limit, predicts one response per accepted request and compares in order
// depends on lsa_rl_pkg
module lsa_list_checker import lsa_rl_pkg::*; #(
    parameter int unsigned DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // lsa_type, state_id, origin_router, sequence_req, check_value
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,   // ok, entry_count, zero pad
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [5:0]   cfg_data,
    output int           fail_count,
    output int           pending_count
);

    entry_t     held [DEPTH];
    int         held_count;
    logic [5:0] cap_limit;
    logic [7:0] responses_due [$];
    int         errors;

    function automatic bit same_key(entry_t a, entry_t b);
        return a.lsa_type == b.lsa_type && a.state_id == b.state_id &&
               a.origin_router == b.origin_router;
    endfunction

    // applies one request to the list copy and returns the response byte
    function automatic logic [7:0] list_apply(kind_t k, entry_t e);
        int   pos;
        int   w;
        int   lim;
        logic ok;
        pos = -1;
        w   = 0;
        ok  = 1'b0;
        case (k)
            KIND_QUEUE: begin
                for (int i = 0; i < held_count; i++)
                    if (pos < 0 && same_key(held[i], e)) pos = i;
                if (pos >= 0) begin
                    held[pos] = e;
                    ok = 1'b1;
                end else begin
                    lim = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
                    if (held_count < lim) begin
                        held[held_count] = e;
                        held_count++;
                        ok = 1'b1;
                    end
                end
            end
            KIND_ACK: begin
                // drop full matches and close the gaps, order kept
                for (int r = 0; r < held_count; r++) begin
                    if (held[r] != e) begin
                        held[w] = held[r];
                        w++;
                    end
                end
                ok = (w != held_count);
                held_count = w;
            end
            KIND_QUERY: begin
                for (int i = 0; i < held_count; i++)
                    if (same_key(held[i], e)) ok = 1'b1;
            end
            default: begin
                held_count = 0;
                ok = 1'b1;
            end
        endcase
        return {1'b0, 6'(held_count), ok};
    endfunction

    initial begin
        errors     = 0;
        held_count = 0;
        cap_limit  = 6'd32;
    end

    always @(posedge aclk) begin : watch
        logic [7:0] due;
        if (!aresetn) begin
            held_count = 0;
            cap_limit  = 6'd32;
            responses_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (responses_due.size() == 0) begin
                    $display("%0t: response %h with no request outstanding", $time, m_tdata);
                    errors++;
                end else begin
                    due = responses_due.pop_front();
                    if (m_tdata[0] !== due[0]) begin
                        $display("%0t: ok expected %0d, got %0d", $time, due[0], m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[6:1] !== due[6:1]) begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, due[6:1], m_tdata[6:1]);
                        errors++;
                    end
                    if (m_tdata[7] !== due[7]) begin
                        $display("%0t: pad bit expected %0d, got %0d", $time, due[7], m_tdata[7]);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;
            if (s_tvalid && s_tready)
                responses_due = {responses_due,
                                 list_apply(kind_t'(s_tuser), entry_t'(s_tdata))};
        end
        pending_count <= responses_due.size();
        fail_count    <= errors;
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// top of the retransmission list bench: clock, reset, request and limit stimulus,
// response back-pressure and the final verdict; depends on lsa_rl_pkg,
// lsa_retransmission_list_core and lsa_list_checker
module tb_top;
    import lsa_rl_pkg::*;

    localparam int unsigned DEPTH = 32;
    localparam int          POOL  = 40;     // more keys than cells, so the list fills up
    localparam int          PHASE_ITEMS = 155;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [5:0]   cfg_data;

    int fail_count;
    int pending;

    // stimulus mode flags shared with the response side
    bit calm;       // no idling on either side
    bit hold_req;   // asks the response side for one long hold-off

    // key pool with two sequence / checksum variants per key, so acks often hit
    entry_t      key_pool [POOL];
    logic [31:0] seq_pool [POOL][2];
    logic [15:0] chk_pool [POOL][2];

    lsa_retransmission_list_core #(.DEPTH(DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lsa_list_checker #(.DEPTH(DEPTH)) u_list_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("lsa_retransmission_list_core test failed");
        $finish;
    end

    // response side: random stalls, or one long hold-off on request so that
    // the output register stays full and the core stops taking requests
    initial begin : response_side
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 12);
            end
        end
    end

    function automatic entry_t make_entry(logic [15:0] t, logic [31:0] id, logic [31:0] rt,
                                          logic [31:0] sq, logic [15:0] ck);
        entry_t e;
        e.lsa_type      = t;
        e.state_id      = id;
        e.origin_router = rt;
        e.sequence_req  = sq;
        e.check_value   = ck;
        return e;
    endfunction

    // entry with every field random
    function automatic entry_t random_entry();
        return make_entry(16'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
    endfunction

    // offers one request and returns once it is accepted; tvalid stays high, so
    // unless a random idle comes first, back-to-back requests go out without a gap
    task automatic send_req(input kind_t k, input entry_t e);
        while (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // waits until every response is back, after first letting the checker
    // count the last accepted request
    task automatic drain;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // limit writes only while the core is idle
    task automatic write_limit(input logic [5:0] v);
        s_tvalid <= 1'b0;
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random request: mostly pool keys with matching variants, some noise
    task automatic draw_request(output kind_t k, output entry_t e);
        int r;
        int idx;
        int v;
        r   = $urandom_range(99);
        idx = $urandom_range(POOL - 1);
        v   = $urandom_range(1);
        if (r < 8) begin
            k = kind_t'($urandom_range(3));
            e = random_entry();
        end else begin
            e = key_pool[idx];
            e.sequence_req = seq_pool[idx][v];
            e.check_value  = chk_pool[idx][v];
            r = $urandom_range(99);
            if (r < 46)      k = KIND_QUEUE;
            else if (r < 76) k = KIND_ACK;
            else if (r < 97) k = KIND_QUERY;
            else             k = KIND_CLEAR;
            // query and clear ignore the fields they do not use
            if (k == KIND_QUERY) begin
                e.sequence_req = $urandom;
                e.check_value  = 16'($urandom);
            end else if (k == KIND_CLEAR) begin
                e = random_entry();
            end
        end
    endtask

    initial begin : stimulus
        entry_t      e;
        entry_t      ka;
        entry_t      kb;
        entry_t      ones;
        kind_t       k;
        logic [5:0]  lim;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_QUEUE;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;

        for (int i = 0; i < POOL; i++) begin
            key_pool[i] = make_entry(16'($urandom), $urandom, $urandom, 32'd0, 16'd0);
            for (int j = 0; j < 2; j++) begin
                seq_pool[i][j] = $urandom;
                chk_pool[i][j] = 16'($urandom);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset limit of 32
        ones = make_entry('1, '1, '1, '1, '1);
        ka   = make_entry(16'h0001, 32'h0a00_0001, 32'hc0a8_0101, 32'h8000_0001, 16'h1234);
        kb   = make_entry(16'h0005, 32'h0a00_0002, 32'hc0a8_0102, 32'h8000_0002, 16'h4321);
        send_req(KIND_CLEAR, ones);
        send_req(KIND_QUERY, '0);                  // empty list, key absent
        send_req(KIND_QUEUE, '0);                  // all-zero entry appended
        send_req(KIND_QUEUE, ones);                // all-ones entry appended
        send_req(KIND_QUEUE, ka);
        e = ones;
        e.sequence_req = 32'h0000_1234;
        e.check_value  = 16'h5678;
        send_req(KIND_QUEUE, e);                   // same key, overwrite in place
        send_req(KIND_QUERY, make_entry('1, '1, '1, 32'h0, 16'h0));   // seq / chk ignored
        send_req(KIND_ACK, ones);                  // stale sequence, no match
        send_req(KIND_ACK, '0);                    // head removed, rest shift left
        send_req(KIND_QUERY, ka);
        e.check_value = 16'h5679;
        send_req(KIND_ACK, e);                     // checksum differs, no match
        e.check_value = 16'h5678;
        send_req(KIND_ACK, e);                     // full match removed
        e = ka;
        e.sequence_req = 32'h8000_0002;
        send_req(KIND_ACK, e);                     // key hit, sequence differs
        send_req(KIND_QUERY, '0);
        send_req(KIND_CLEAR, '0);
        send_req(KIND_ACK, ka);                    // nothing to remove on empty list

        // zero limit: every new key refused
        write_limit(6'd0);
        send_req(KIND_QUEUE, kb);
        // small limit, then one below the count: updates still pass
        write_limit(6'd2);
        send_req(KIND_QUEUE, ka);
        send_req(KIND_QUEUE, kb);
        send_req(KIND_QUEUE, ones);                // list at limit, refused
        write_limit(6'd1);
        send_req(KIND_QUEUE, make_entry(16'h0003, 32'h1, 32'h2, 32'h3, 16'h4));
        e = kb;
        e.sequence_req = 32'h8000_0003;
        send_req(KIND_QUEUE, e);                   // update of a held key
        send_req(KIND_QUERY, kb);

        // random phases across several limits; 63 exceeds the depth
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       lim = 6'd63;
                1:       lim = 6'd0;
                2:       lim = 6'd3;
                3:       lim = 6'd17;
                4:       lim = 6'd32;
                5:       lim = 6'd1;
                default: lim = 6'($urandom_range(63));
            endcase
            write_limit(lim);
            calm = (p == 4);
            if (p == 0)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                draw_request(k, e);
                send_req(k, e);
            end
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("lsa_retransmission_list_core test passed");
        else
            $display("lsa_retransmission_list_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lsa_rl_pkg.sv
rtl/core/lsa_rl_cell.sv
rtl/core/lsa_retransmission_list_core.sv
bench/lsa_list_checker.sv
bench/tb_top.sv
